@@ sv/hilditch_thinning_2d_macros.svh @@
// assertion macros shared by the checker
`ifndef HILDITCH_THINNING_2D_MACROS_SVH
`define HILDITCH_THINNING_2D_MACROS_SVH
`define HT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define HT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

@@ sv/ht_pkg.sv @@
// shared types and constants for the hilditch thinning block
package ht_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'b1;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam logic [1:0] PIX_BG   = 2'd0;
    localparam logic [1:0] PIX_FG   = 2'd1;
    localparam logic [1:0] PIX_PEND = 2'd2;

    // 8-connectivity number, n[k]: 0 bg, 1 fg, 2 pending; index 0..7 = E,NE,N,NW,W,SW,S,SE
    function automatic logic [2:0] conn8(input logic [7:0] bgm);
        logic [2:0] s;
        s = 3'd0;
        for (int k = 0; k < 8; k += 2) begin
            if (bgm[k] && !(bgm[(k+1)%8] && bgm[(k+2)%8])) s = s + 3'd1;
        end
        return s;
    endfunction
endpackage

@@ sv/ht_ram.sv @@
// generic single-port ram with registered read
module ht_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ sv/hilditch_thinning_2d.sv @@
// top level of the hilditch thinning block
//
// usage: write frame_width / frame_height on the config channel (index 0 / 1),
// each write restarts the frame. then send width*height load transfers
// (tdata[0] op=0, tdata[1] pixel) in raster order. after the last pixel
// the block thins the frame in place and holds s_axis_tready low meanwhile.
// read transfers (op=1) then each return one pixel on the master side,
// tdata[0] pixel_out, tlast on the final pixel; reads while loading give no
// result. a load during readout abandons it and starts a new frame.
// loads are taken back to back; a read goes through the single ram port as
// read, wait and present, and the result is held in the output register.
// thinning runs nine fetch/collect pairs and one decide step per pixel per
// pass, plus one clear sweep (read, write per pixel) per pass; the single ram
// port sets this, since each pixel's 3x3 window is fetched one entry at a time.
// reset: synchronous active low, back to loading with a 256x256 frame clamped to MAX_WIDTH/MAX_HEIGHT.
// a stalled master side holds tdata/tlast; the output register frees the
// slave side only after the result is taken.
module hilditch_thinning_2d #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] op, [1] pixel_in
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] pixel_out
    output logic       m_axis_tlast,   // frame_last
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [ht_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import ht_pkg::*;
    localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_RWAIT = 8'b0000_0100,
        S_TFET  = 8'b0000_1000,   // issue neighbour fetch
        S_TCOL  = 8'b0001_0000,   // collect neighbour
        S_TDEC  = 8'b0010_0000,   // decide and maybe write pending
        S_CRD   = 8'b0100_0000,   // clear sweep read
        S_CWR   = 8'b1000_0000    // clear sweep write
    } t_state;

    t_state r_st, n_st;
    logic [XW-1:0] r_w;
    logic [YW-1:0] r_h;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [3:0]    r_k;          // neighbour index 0 center, 1..8
    logic [1:0]    r_nb [9];
    logic          r_del;
    logic          r_reading;
    logic [AW:0]   r_pos;
    logic          r_ov, r_pix, r_last;
    logic          r_rlast;
    logic          inframe_q;

    logic          we;
    logic [AW-1:0] addr;
    logic [1:0]    wdata, rdata;

    ht_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    // total pixels and clamped config
    logic [AW:0] total;
    assign total = (AW+1)'(r_w) * (AW+1)'(r_h);

    function automatic int unsigned clampd(input logic [8:0] v, input int unsigned mx);
        int unsigned r;
        if (v == 9'd0) r = 1;
        else if (32'(v) > mx) r = mx;
        else r = 32'(v);
        return r;
    endfunction

    // neighbour offsets for fetch index r_k
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic                 inframe;
    always_comb begin
        nx = signed'({2'b00, r_x});
        ny = signed'({2'b00, r_y});
        unique case (r_k)
            4'd1: nx = nx + 2'sd1;
            4'd2: begin nx = nx + 2'sd1; ny = ny - 2'sd1; end
            4'd3: ny = ny - 2'sd1;
            4'd4: begin nx = nx - 2'sd1; ny = ny - 2'sd1; end
            4'd5: nx = nx - 2'sd1;
            4'd6: begin nx = nx - 2'sd1; ny = ny + 2'sd1; end
            4'd7: ny = ny + 2'sd1;
            4'd8: begin nx = nx + 2'sd1; ny = ny + 2'sd1; end
            default: ;
        endcase
        inframe = (nx >= 0) && (ny >= 0) && (nx < signed'({2'b00, r_w}))
               && (ny < signed'({2'b00, r_h}));
    end
    logic [AW:0] naddr;
    assign naddr = (AW+1)'(ny[YW-1:0]) * (AW+1)'(r_w) + (AW+1)'(nx[XW-1:0]);
    logic [AW:0] caddr;
    assign caddr = (AW+1)'(r_y) * (AW+1)'(r_w) + (AW+1)'(r_x);

    // deletion test on the collected window
    logic deletable;
    always_comb begin
        logic [7:0] bgm, fgm, nzm, tmp;
        logic ok;
        for (int i = 0; i < 8; i++) begin
            bgm[i] = (r_nb[i+1] != PIX_FG) && (r_nb[i+1] != PIX_PEND);
            fgm[i] = (r_nb[i+1] == PIX_FG);
            nzm[i] = !bgm[i];
        end
        ok = (r_nb[0] == PIX_FG);
        ok = ok && (bgm[0] || bgm[2] || bgm[4] || bgm[6]);
        ok = ok && ($countones(nzm) >= 2);
        ok = ok && (fgm != 8'd0);
        ok = ok && (conn8(bgm) == 3'd1);
        for (int i = 0; i < 8; i++) begin
            tmp = bgm;
            tmp[i] = 1'b1;
            if (r_nb[i+1] == PIX_PEND && conn8(tmp) != 3'd1) ok = 1'b0;
        end
        deletable = ok;
    end

    logic in_xfer, out_xfer, cfg_xfer;
    assign o_cfg_ready   = (r_st == S_LOAD) || (r_st == S_READ);
    assign s_axis_tready = ((r_st == S_LOAD) || (r_st == S_READ)) && !r_ov;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_pix};
    assign m_axis_tlast  = r_last;

    // ram port and next state
    always_comb begin
        n_st  = r_st;
        we    = 1'b0;
        addr  = r_pos[AW-1:0];
        wdata = {1'b0, s_axis_tdata[1]};
        unique case (r_st)
            S_LOAD, S_READ: begin
                if (cfg_xfer) begin
                    n_st = S_LOAD;
                end else if (in_xfer) begin
                    if (s_axis_tdata[0] == OP_LOAD) begin
                        we = 1'b1;
                        if (r_reading) addr = '0;
                        if (r_reading ? (total == (AW+1)'(1))
                                      : (r_pos + 1'b1 >= total)) n_st = S_TFET;
                        else n_st = S_LOAD;
                    end else if (r_reading) begin
                        n_st = S_RWAIT;
                    end
                end
            end
            S_RWAIT: n_st = S_READ;
            S_TFET: begin
                addr = naddr[AW-1:0];
                n_st = S_TCOL;
            end
            S_TCOL: n_st = (r_k == 4'd8) ? S_TDEC : S_TFET;
            S_TDEC: begin
                addr  = caddr[AW-1:0];
                wdata = PIX_PEND;
                we    = deletable;
                n_st  = ((r_x == r_w - 1'b1) && (r_y == r_h - 1'b1)) ? S_CRD : S_TFET;
            end
            S_CRD: n_st = S_CWR;
            S_CWR: begin
                wdata = PIX_BG;
                we    = (rdata == PIX_PEND);
                if (r_pos + 1'b1 >= total) n_st = r_del ? S_TFET : S_READ;
                else n_st = S_CRD;
            end
            default: n_st = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_reading <= 1'b0; r_pos <= '0; r_ov <= 1'b0;
            r_x <= '0; r_y <= '0; r_k <= '0; r_del <= 1'b0;
            r_w <= XW'(clampd(9'd256, MAX_WIDTH)); r_h <= YW'(clampd(9'd256, MAX_HEIGHT));
        end else begin
            r_st <= n_st;
            if (out_xfer) r_ov <= 1'b0;
            if (cfg_xfer) begin
                if (i_cfg_index == REG_WIDTH) r_w <= XW'(clampd(i_cfg_data, MAX_WIDTH));
                else r_h <= YW'(clampd(i_cfg_data, MAX_HEIGHT));
                r_pos <= '0; r_reading <= 1'b0;
            end else begin
                unique case (r_st)
                    S_LOAD, S_READ: if (in_xfer) begin
                        if (s_axis_tdata[0] == OP_LOAD) begin
                            r_reading <= 1'b0;
                            r_pos <= r_reading ? (AW+1)'(1) : r_pos + 1'b1;
                            r_x <= '0; r_y <= '0; r_k <= '0;
                        end else if (r_reading) begin
                            r_rlast <= (r_pos + 1'b1 == total);
                            r_pos <= (r_pos + 1'b1 == total) ? '0 : r_pos + 1'b1;
                            if (r_pos + 1'b1 == total) r_reading <= 1'b0;
                        end
                    end
                    S_RWAIT: begin
                        r_ov <= 1'b1; r_pix <= (rdata == PIX_FG); r_last <= r_rlast;
                    end
                    S_TFET: r_nb[r_k] <= PIX_BG;
                    S_TCOL: begin
                        r_nb[r_k] <= inframe_q ? rdata : PIX_BG;
                        r_k <= r_k + 4'd1;
                    end
                    S_TDEC: begin
                        r_k <= '0;
                        if (deletable) r_del <= 1'b1;
                        if (r_x == r_w - 1'b1) begin
                            r_x <= '0; r_y <= r_y + 1'b1;
                        end else r_x <= r_x + 1'b1;
                        r_pos <= '0;
                    end
                    S_CRD: ;
                    S_CWR: begin
                        if (r_pos + 1'b1 >= total) begin
                            r_pos <= '0; r_x <= '0; r_y <= '0; r_del <= 1'b0;
                            if (!r_del) r_reading <= 1'b1;
                        end else r_pos <= r_pos + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // fetch bookkeeping: r_k advances after collect, inframe sampled at fetch
    always_ff @(posedge i_clk) begin
        if (r_st == S_TFET) inframe_q <= inframe;
    end
endmodule

@@ sv/hilditch_thinning_2d_chk.sv @@
// port-level checker for the hilditch thinning block
`include "hilditch_thinning_2d_macros.svh"
module hilditch_thinning_2d_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    `HT_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)
    `HT_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `HT_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
endmodule

bind hilditch_thinning_2d hilditch_thinning_2d_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
